[rtl/pcfl_pkg.sv]
`timescale 1ns / 1ps

package pcfl_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int CORES_DEF      = 8;
  localparam int PAGES_DEF      = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  // Widest fields that the parameter ranges can call for.
  localparam int CORE_MAX_W = 6;
  localparam int IDX_MAX_W  = 20;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0] REGION_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] KERNEL_END_RST  = 32'h8000_0000;
  localparam logic [31:0] TOP_ADDRESS_RST = 32'h8800_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BASE = 2'd0,
    REG_KERNEL_END  = 2'd1,
    REG_TOP_ADDRESS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OOM      = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_BAD   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE,
    ST_AHEAD,
    ST_ALINK
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  core;
    logic [31:0] page_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [2:0]  source_core;
  } rsp_t;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    cmd_e                  op;
    logic [CORE_MAX_W-1:0] core;
    logic [IDX_MAX_W-1:0]  idx;
  } cmd_t;

endpackage

[rtl/pcfl_queue.sv]
`timescale 1ns / 1ps

module pcfl_queue
  import pcfl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/pcfl_front.sv]
`timescale 1ns / 1ps

module pcfl_front
  import pcfl_pkg::*;
#(
  parameter int CORES      = CORES_DEF,
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  req_t        item_i,
  input  logic [31:0] region_base_i,
  input  logic [31:0] kernel_end_i,
  input  logic [31:0] top_address_i,
  output cmd_t        cmd_o
);

  localparam int OFF_W = $clog2(PAGE_BYTES);

  logic [6:0]  core_red;
  logic [31:0] diff;
  logic [31:0] idx_wide;
  logic        aligned;
  logic        in_range;
  logic        bad;

  // A core number at or above CORES wraps; the value is only three bits wide.
  always_comb begin
    core_red = 7'(item_i.core);
    for (int k = 0; k < 8; k++) begin
      if (core_red >= 7'(CORES)) begin
        core_red = core_red - 7'(CORES);
      end
    end
  end

  assign aligned  = (item_i.page_address & 32'(PAGE_BYTES - 1)) == '0;
  assign diff     = item_i.page_address - region_base_i;
  assign idx_wide = diff >> OFF_W;
  assign in_range = {1'b0, idx_wide} < 33'(PAGES);

  assign bad = !aligned
            || (item_i.page_address < kernel_end_i)
            || (item_i.page_address >= top_address_i)
            || (item_i.page_address < region_base_i)
            || !in_range;

  always_comb begin
    cmd_o.core = CORE_MAX_W'(core_red);
    cmd_o.idx  = IDX_MAX_W'(idx_wide);
    if (item_i.kind == KIND_FREE) begin
      cmd_o.op = bad ? CMD_BAD : CMD_FREE;
    end else begin
      cmd_o.op = CMD_ALLOC;
    end
  end

endmodule

[rtl/pcfl_back.sv]
`timescale 1ns / 1ps

module pcfl_back
  import pcfl_pkg::*;
#(
  parameter int CORES      = CORES_DEF,
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] region_base_i,
  input  logic        cmd_empty_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output rsp_t        res_o
);

  localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int IDX_W  = $clog2(PAGES);
  localparam int OFF_W  = $clog2(PAGE_BYTES);

  state_e state_q, state_d;

  logic [CORE_W-1:0] cur_core_q, cur_core_d;
  logic [IDX_W-1:0]  cur_idx_q, cur_idx_d;
  logic [CORES-1:0]  hv_q;

  // Head page of each list; the valid bits above say which lists hold pages.
  logic [IDX_W-1:0] head_mem [CORES];
  logic [IDX_W-1:0] head_rd_q;
  logic [CORE_W-1:0] head_raddr, head_waddr;
  logic [IDX_W-1:0]  head_wdata;
  logic              head_we;

  // Link of each free page: valid bit on top, next page index below.
  logic [IDX_W:0]   link_mem [PAGES];
  logic [IDX_W:0]   link_rd_q;
  logic [IDX_W-1:0] link_raddr, link_waddr;
  logic [IDX_W:0]   link_wdata;
  logic             link_we;

  logic              hv_we, hv_wval;
  logic              accept;
  logic [CORE_W-1:0] start;
  logic [2*CORES-1:0] hv_dbl;
  logic [CORES-1:0]  hv_rot;
  logic [CORE_W-1:0] offset;
  logic [CORE_W:0]   sel_sum;
  logic [CORE_W-1:0] sel_core;
  logic              any_free;

  assign accept   = (state_q == ST_IDLE) && !cmd_empty_i && !res_full_i;
  assign start    = cmd_i.core[CORE_W-1:0];
  assign any_free = |hv_q;

  // Rotating priority: the first non-empty list at or after the requesting core.
  always_comb begin
    hv_dbl = {hv_q, hv_q};
    hv_rot = CORES'(hv_dbl >> start);
    offset = '0;
    for (int k = CORES - 1; k >= 0; k--) begin
      if (hv_rot[k]) begin
        offset = CORE_W'(k);
      end
    end
    sel_sum = (CORE_W + 1)'(start) + (CORE_W + 1)'(offset);
    if (sel_sum >= (CORE_W + 1)'(CORES)) begin
      sel_sum = sel_sum - (CORE_W + 1)'(CORES);
    end
    sel_core = sel_sum[CORE_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.op)
            CMD_FREE:  state_d = ST_FREE;
            CMD_ALLOC: state_d = any_free ? ST_AHEAD : ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_FREE:  state_d = ST_IDLE;
      ST_AHEAD: state_d = ST_ALINK;
      ST_ALINK: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.status          = STATUS_OK;
    res_o.granted_address = '0;
    res_o.source_core     = 3'(cur_core_q);
    cur_core_d = cur_core_q;
    cur_idx_d  = cur_idx_q;
    head_raddr = cur_core_q;
    head_we    = 1'b0;
    head_waddr = cur_core_q;
    head_wdata = cur_idx_q;
    link_raddr = head_rd_q;
    link_we    = 1'b0;
    link_waddr = cur_idx_q;
    link_wdata = {hv_q[cur_core_q], head_rd_q};
    hv_we      = 1'b0;
    hv_wval    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_pop_o = 1'b1;
          cur_idx_d = cmd_i.idx[IDX_W-1:0];
          unique case (cmd_i.op)
            CMD_FREE: begin
              cur_core_d = start;
              head_raddr = start;
            end
            CMD_ALLOC: begin
              cur_core_d = sel_core;
              head_raddr = sel_core;
              if (!any_free) begin
                res_push_o        = 1'b1;
                res_o.status      = STATUS_OOM;
                res_o.source_core = 3'(start);
              end
            end
            default: begin
              res_push_o        = 1'b1;
              res_o.status      = STATUS_BAD_FREE;
              res_o.source_core = 3'(start);
            end
          endcase
        end
      end
      ST_FREE: begin
        // The old head becomes the link of the page just pushed.
        link_we    = 1'b1;
        head_we    = 1'b1;
        hv_we      = 1'b1;
        res_push_o = 1'b1;
      end
      ST_AHEAD: begin
        cur_idx_d = head_rd_q;
      end
      ST_ALINK: begin
        head_we    = 1'b1;
        head_wdata = link_rd_q[IDX_W-1:0];
        hv_we      = 1'b1;
        hv_wval    = link_rd_q[IDX_W];
        res_push_o = 1'b1;
        res_o.granted_address = region_base_i + (32'(cur_idx_q) << OFF_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hv_q       <= '0;
      cur_core_q <= '0;
      cur_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      cur_core_q <= cur_core_d;
      cur_idx_q  <= cur_idx_d;
      if (hv_we) begin
        hv_q[cur_core_q] <= hv_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[link_raddr];
  end

endmodule

[rtl/per_core_page_free_lists.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload        Accepted when
// ------------------------------------------------------------------------
// request   push / full             in_item_i      push high, full low
// result    empty / pop             out_item_o     pop high, empty low
// config    cfg_we_i                cfg_index_i,   cfg_we_i high
//                                   cfg_data_i
//
// The back end works on one item at a time. A free goes through its idle and
// free states, an allocate through idle, head and link (head memory read, link
// memory read, write-back); a bad free or OOM answer comes from idle.
// Reset empties every list at once through per-core valid bits; no clearing pass.
// Full rises when the two-entry command queue is full; the back end waits
// while the two-entry result queue is full.
module per_core_page_free_lists
  import pcfl_pkg::*;
#(
  parameter int CORES      = CORES_DEF,
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  req_t                 in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output rsp_t                 out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [31:0] region_base_q, kernel_end_q, top_address_q;
  cmd_t        front_cmd, queued_cmd;
  rsp_t        back_res;
  logic        cmd_empty, cmd_pop;
  logic        res_full, res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= REGION_BASE_RST;
      kernel_end_q  <= KERNEL_END_RST;
      top_address_q <= TOP_ADDRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REGION_BASE: region_base_q <= cfg_data_i;
        REG_KERNEL_END:  kernel_end_q  <= cfg_data_i;
        REG_TOP_ADDRESS: top_address_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcfl_front #(
    .CORES      (CORES),
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .item_i        (in_item_i),
    .region_base_i (region_base_q),
    .kernel_end_i  (kernel_end_q),
    .top_address_i (top_address_q),
    .cmd_o         (front_cmd)
  );

  pcfl_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (queued_cmd),
    .empty_o (cmd_empty)
  );

  pcfl_back #(
    .CORES      (CORES),
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .region_base_i (region_base_q),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (queued_cmd),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (back_res)
  );

  pcfl_queue #(
    .WIDTH ($bits(rsp_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

[rtl/pcfl_checker.sv]
`timescale 1ns / 1ps

module pcfl_checker
  import pcfl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input req_t in_item_i,
  input logic empty,
  input logic pop,
  input rsp_t out_item_o
);

  // Only a successful allocate hands out an address.
  a_addr_only_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status != STATUS_OK) |-> out_item_o.granted_address == '0)
    else $error("address given with a failing status");

  a_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.status == STATUS_OK || out_item_o.status == STATUS_OOM
                || out_item_o.status == STATUS_BAD_FREE))
    else $error("result item carries an unknown status");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result item changed or vanished");

  // Nothing can be waiting on the result side straight out of reset.
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result item present right after reset");

endmodule

bind per_core_page_free_lists pcfl_checker u_checker (.*);

[sim/page_list_checker.sv]
`timescale 1ns / 1ps

module page_list_checker
  import pcfl_pkg::*;
#(
  parameter int CORES      = CORES_DEF,
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  req_t                 req_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  rsp_t                 rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   mismatch_count_o,
  output int                   answers_due_o
);

  localparam int IDX_W = $clog2(PAGES);

  logic [31:0]      region_base;
  logic [31:0]      kernel_end;
  logic [31:0]      top_address;
  bit               head_ok   [CORES];
  logic [IDX_W-1:0] head_page [CORES];
  bit               link_ok   [PAGES];
  logic [IDX_W-1:0] link_page [PAGES];
  rsp_t             answers_due [$];
  int               mismatches;

  assign mismatch_count_o = mismatches;

  // Works out the answer to one request and updates the free lists as the block does.
  function automatic rsp_t serve_request(req_t rq);
    rsp_t             rs;
    int unsigned      home;
    int unsigned      src;
    logic [31:0]      pa;
    logic [31:0]      idx;
    logic [IDX_W-1:0] pg;
    rs = '0;
    home = rq.core % CORES;
    rs.source_core = 3'(home);
    if (rq.kind == KIND_FREE) begin
      pa  = rq.page_address;
      idx = (pa - region_base) / 32'(PAGE_BYTES);
      if ((pa % 32'(PAGE_BYTES)) != 0 || pa < kernel_end || pa >= top_address ||
          pa < region_base || idx >= 32'(PAGES)) begin
        rs.status = STATUS_BAD_FREE;
      end else begin
        link_ok[idx]    = head_ok[home];
        link_page[idx]  = head_page[home];
        head_ok[home]   = 1'b1;
        head_page[home] = idx[IDX_W-1:0];
        rs.status       = STATUS_OK;
      end
    end else begin
      rs.status = STATUS_OOM;
      // The own list first, then the others in turn from the next core up.
      for (int k = 0; k < CORES; k++) begin
        src = (home + k) % CORES;
        if (head_ok[src]) begin
          pg                 = head_page[src];
          head_ok[src]       = link_ok[pg];
          head_page[src]     = link_page[pg];
          rs.status          = STATUS_OK;
          rs.granted_address = region_base + 32'(pg) * 32'(PAGE_BYTES);
          rs.source_core     = 3'(src);
          break;
        end
      end
    end
    return rs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      region_base = REGION_BASE_RST;
      kernel_end  = KERNEL_END_RST;
      top_address = TOP_ADDRESS_RST;
      for (int c = 0; c < CORES; c++) begin
        head_ok[c] = 1'b0;
      end
      answers_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REGION_BASE: region_base = cfg_data_i;
          REG_KERNEL_END:  kernel_end  = cfg_data_i;
          REG_TOP_ADDRESS: top_address = cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, got status %0d address %h core %0d",
                   $time, rsp_i.status, rsp_i.granted_address, rsp_i.source_core);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_i.status);
            mismatches++;
          end
          if (rsp_i.granted_address !== want.granted_address) begin
            $display("%0t: address expected %h, got %h", $time, want.granted_address,
                     rsp_i.granted_address);
            mismatches++;
          end
          if (rsp_i.source_core !== want.source_core) begin
            $display("%0t: source core expected %0d, got %0d", $time, want.source_core,
                     rsp_i.source_core);
            mismatches++;
          end
        end
      end
      if (push_i && !full_i) begin
        answers_due.push_back(serve_request(req_i));
      end
    end
    answers_due_o = answers_due.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pcfl_pkg::*;

  localparam int PAGE_SIZE = PAGE_BYTES_DEF;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  req_t                 in_item   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  rsp_t                 out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  int                   mismatch_count;
  int                   answers_due;

  logic [31:0] cur_base = REGION_BASE_RST;
  logic [31:0] cur_kend = KERNEL_END_RST;
  logic [31:0] cur_top  = TOP_ADDRESS_RST;
  logic [31:0] page_pool [$];
  kind_e       kinds_sent [$];
  status_e     last_status = STATUS_OK;
  int          fresh_next = 0;
  int          send_gap_max = 12;
  int          take_gap_max = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  per_core_page_free_lists dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  page_list_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .req_i            (in_item),
    .empty_i          (empty),
    .pop_i            (pop),
    .rsp_i            (out_item),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .answers_due_o    (answers_due)
  );

  function automatic req_t make_req(kind_e k, logic [2:0] c, logic [31:0] a);
    req_t rq;
    rq.kind         = k;
    rq.core         = c;
    rq.page_address = a;
    return rq;
  endfunction

  // Mostly allocations and frees of pages handed out earlier, with fresh pages to
  // fill the lists and a little noise around the window edges.
  function automatic req_t next_request();
    req_t        rq;
    int unsigned roll;
    int unsigned slot;
    logic [31:0] lo;
    rq.core = 3'($urandom_range(7));
    rq.kind = KIND_FREE;
    roll = $urandom_range(99);
    lo = (cur_kend > cur_base) ? cur_kend : cur_base;
    lo = (lo + 32'(PAGE_SIZE - 1)) & ~32'(PAGE_SIZE - 1);
    if (roll < 45) begin
      rq.kind         = KIND_ALLOC;
      rq.page_address = $urandom();
    end else if (roll < 75 && page_pool.size() != 0) begin
      slot            = $urandom_range(page_pool.size() - 1);
      rq.page_address = page_pool[slot];
      page_pool.delete(slot);
    end else if (roll < 92) begin
      rq.page_address = lo + 32'(fresh_next) * 32'(PAGE_SIZE);
      fresh_next++;
    end else begin
      case ($urandom_range(5))
        0:       rq.page_address = cur_top;
        1:       rq.page_address = cur_kend - 32'(PAGE_SIZE);
        2:       rq.page_address = cur_base - 32'(PAGE_SIZE);
        3:       rq.page_address = cur_base + 32'(PAGES_DEF) * 32'(PAGE_SIZE);
        4:       rq.page_address = cur_kend + 32'd1;
        default: rq.page_address = $urandom();
      endcase
    end
    return rq;
  endfunction

  // Starts and ends at a falling edge; push is left high for a following item.
  task automatic send_item(input req_t rq);
    int gap;
    gap = $urandom_range(send_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push    <= 1'b1;
    in_item <= rq;
    do @(posedge clk_i); while (full);
    kinds_sent.push_back(kind_e'(rq.kind));
    @(negedge clk_i);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (answers_due != 0) @(negedge clk_i);
  endtask

  initial begin : result_taker
    int    stall;
    int    taken;
    kind_e k;
    taken = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 32 == 0) take_gap_max = ($urandom_range(1) != 0) ? 12 : 0;
      stall = $urandom_range(take_gap_max);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      k = kinds_sent.pop_front();
      last_status = status_e'(out_item.status);
      if (k == KIND_ALLOC && out_item.status == STATUS_OK) begin
        page_pool.push_back(out_item.granted_address);
      end
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int count;
    count = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(make_req(KIND_ALLOC, 3'd2, 32'h0000_0000));
    send_item(make_req(KIND_FREE,  3'd0, 32'h8000_0000));
    send_item(make_req(KIND_FREE,  3'd7, 32'h87FF_F000));
    send_item(make_req(KIND_FREE,  3'd1, 32'h8800_0000));
    send_item(make_req(KIND_FREE,  3'd1, 32'h7FFF_F000));
    send_item(make_req(KIND_FREE,  3'd3, 32'h8000_0800));
    send_item(make_req(KIND_FREE,  3'd4, 32'hFFFF_FFFF));
    send_item(make_req(KIND_FREE,  3'd5, 32'h0000_0000));
    send_item(make_req(KIND_ALLOC, 3'd3, 32'hFFFF_FFFF));
    send_item(make_req(KIND_ALLOC, 3'd1, 32'h0000_0000));
    send_item(make_req(KIND_ALLOC, 3'd7, 32'h0000_0000));
    // A double free leaves the page linked to itself; handing it to an empty list
    // afterwards cuts the loop again.
    send_item(make_req(KIND_FREE,  3'd6, 32'h8000_5000));
    send_item(make_req(KIND_FREE,  3'd6, 32'h8000_5000));
    send_item(make_req(KIND_ALLOC, 3'd6, 32'h0000_0000));
    send_item(make_req(KIND_FREE,  3'd5, 32'h8000_5000));
    send_item(make_req(KIND_ALLOC, 3'd6, 32'h0000_0000));
    send_item(make_req(KIND_ALLOC, 3'd6, 32'h0000_0000));
    send_item(make_req(KIND_ALLOC, 3'd0, 32'h0000_0000));

    for (int p = 0; p < 5; p++) begin
      // Empty every list so that no page of the previous window is left behind.
      for (int n = 0; n < 400; n++) begin
        send_item(make_req(KIND_ALLOC, 3'($urandom_range(7)), $urandom()));
        settle();
        if (last_status == STATUS_OOM) break;
      end
      page_pool.delete();
      case (p)
        0: begin
          cur_base = 32'h8000_0000; cur_kend = 32'h8000_0000; cur_top = 32'h8800_0000;
          count = 150;
        end
        1: begin
          cur_base = 32'h0000_0000; cur_kend = 32'h0000_0000; cur_top = 32'hFFFF_FFFF;
          count = 150;
        end
        2: begin
          cur_base = 32'h8000_0800; cur_kend = 32'h8001_0000; cur_top = 32'h8010_0000;
          count = 120;
        end
        3: begin
          cur_base = 32'hFFFF_0000; cur_kend = 32'h0000_1000; cur_top = 32'hFFFF_FFFF;
          count = 100;
        end
        default: begin
          cur_base = 32'hFFFF_FFFF; cur_kend = 32'hFFFF_FFFF; cur_top = 32'h0000_0000;
          count = 30;
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= REG_REGION_BASE;
      cfg_data  <= cur_base;
      @(negedge clk_i);
      cfg_index <= REG_KERNEL_END;
      cfg_data  <= cur_kend;
      @(negedge clk_i);
      cfg_index <= REG_TOP_ADDRESS;
      cfg_data  <= cur_top;
      @(negedge clk_i);
      cfg_we <= 1'b0;
      fresh_next = 0;
      for (int i = 0; i < count; i++) begin
        if (i % 32 == 0) send_gap_max = ($urandom_range(1) != 0) ? 12 : 0;
        send_item(next_request());
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
